FILE: sv/iyu_pkg.sv
// Types and constants shared by the yaw unwrap block.
package iyu_pkg;

    localparam int CNT_W      = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_BYTE  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_TYPE = 1'd1;

    localparam logic [7:0] SYNC_BYTE_RST  = 8'h55;
    localparam logic [7:0] ANGLE_TYPE_RST = 8'h53;

    localparam logic [CNT_W-1:0] TYPE_POS     = 4'd1;
    localparam logic [CNT_W-1:0] YAW_LOW_POS  = 4'd6;
    localparam logic [CNT_W-1:0] YAW_HIGH_POS = 4'd7;

    localparam logic [15:0] RAW_90  = 16'd16384;
    localparam logic [15:0] RAW_270 = 16'd49152;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       mode;
    } sample_t;

    typedef struct packed {
        logic               mode_out;
        logic               angle_valid;
        logic signed [31:0] unwrapped_yaw;
        logic [31:0]        yaw_delta;
    } result_t;

    typedef struct packed {
        logic        mode;
        logic        is_angle;
        logic [15:0] raw_yaw;
    } frame_t;

endpackage

FILE: sv/iyu_fifo.sv
// Small register queue used between the parser and the unwrap stage and at the output.
module iyu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: sv/iyu_front.sv
// Frame parser: header sync, byte counting, field capture and type classification.
module iyu_front #(
    parameter int FRAME_LEN = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [iyu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [iyu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           accept,
    input  iyu_pkg::sample_t               sample,
    output logic                           frame_push,
    output iyu_pkg::frame_t                frame
);

    import iyu_pkg::*;

    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sync_reg;
    logic [7:0]       atype_reg;
    logic [7:0]       type_reg;
    logic [7:0]       low_reg;
    logic [7:0]       high_reg;
    logic             take;

    assign take       = accept && !(count_reg == '0 && sample.rx_byte != sync_reg);
    assign frame_push = take && (count_reg == LAST_POS);

    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            count_next = (count_reg == LAST_POS) ? '0 : count_reg + 1'b1;
        end
    end

    always_comb
    begin
        frame.mode          = sample.mode;
        frame.is_angle      = (type_reg == atype_reg);
        frame.raw_yaw[15:8] = (count_reg == YAW_HIGH_POS) ? sample.rx_byte : high_reg;
        frame.raw_yaw[7:0]  = (count_reg == YAW_LOW_POS) ? sample.rx_byte : low_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sync_reg  <= SYNC_BYTE_RST;
            atype_reg <= ANGLE_TYPE_RST;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_SYNC_BYTE:  sync_reg  <= cfg_wdata;
                    REG_ANGLE_TYPE: atype_reg <= cfg_wdata;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (count_reg == TYPE_POS)
            begin
                type_reg <= sample.rx_byte;
            end
            if (count_reg == YAW_LOW_POS)
            begin
                low_reg <= sample.rx_byte;
            end
            if (count_reg == YAW_HIGH_POS)
            begin
                high_reg <= sample.rx_byte;
            end
        end
    end

endmodule

FILE: sv/iyu_back.sv
// Unwrap stage: per-mode turn tracking, unwrapped yaw and start-to-end delta.
module iyu_back #(
    parameter int TURN_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_avail,
    input  iyu_pkg::frame_t  frame,
    input  logic             res_full,
    output logic             frame_pop,
    output logic             res_push,
    output iyu_pkg::result_t res
);

    import iyu_pkg::*;

    localparam logic signed [TURN_BITS-1:0] TMAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TMIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    logic [15:0]                 last_raw_reg [2];
    logic signed [TURN_BITS-1:0] turn_reg [2];
    logic signed [31:0]          start_yaw_reg;

    logic                        go;
    logic [15:0]                 last;
    logic signed [TURN_BITS-1:0] t_cur, t_new;
    logic signed [15:0]          t_ext;
    logic signed [31:0]          unw;
    logic [32:0]                 d_fwd, d_rev;

    assign go        = frame_avail && !res_full;
    assign frame_pop = go;
    assign res_push  = go;

    always_comb
    begin
        last  = last_raw_reg[frame.mode];
        t_cur = turn_reg[frame.mode];
        t_new = t_cur;
        if (last < RAW_90 && frame.raw_yaw > RAW_270)
        begin
            if (t_cur != TMIN)
            begin
                t_new = t_cur - 1'b1;
            end
        end
        else if (last > RAW_270 && frame.raw_yaw < RAW_90)
        begin
            if (t_cur != TMAX)
            begin
                t_new = t_cur + 1'b1;
            end
        end
        t_ext = 16'(t_new);
        unw   = {t_ext, frame.raw_yaw};
        d_fwd = {unw[31], unw} - {start_yaw_reg[31], start_yaw_reg};
        d_rev = {start_yaw_reg[31], start_yaw_reg} - {unw[31], unw};
    end

    always_comb
    begin
        res.mode_out      = frame.mode;
        res.angle_valid   = frame.is_angle;
        res.unwrapped_yaw = '0;
        res.yaw_delta     = '0;
        if (frame.is_angle)
        begin
            res.unwrapped_yaw = unw;
            if (frame.mode)
            begin
                res.yaw_delta = d_fwd[32] ? d_rev[31:0] : d_fwd[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg[0] <= '0;
            last_raw_reg[1] <= '0;
            turn_reg[0]     <= '0;
            turn_reg[1]     <= '0;
            start_yaw_reg   <= '0;
        end
        else if (go && frame.is_angle)
        begin
            last_raw_reg[frame.mode] <= frame.raw_yaw;
            turn_reg[frame.mode]     <= t_new;
            if (!frame.mode)
            begin
                start_yaw_reg <= unw;
            end
        end
    end

endmodule

FILE: sv/imu_frame_yaw_unwrap.sv
// Top level of the IMU serial frame yaw unwrap block.
//
// Input channel: one received serial byte with its mode bit per word, taken
// when push is high and full is low; a new byte can be taken each such cycle.
// The parser syncs on the header byte, counts FRAME_LEN bytes and, on the
// last one, hands a frame word to a two-entry queue. The unwrap stage takes
// one frame word per cycle unless the output queue is full, updates the
// per-mode turn count and start yaw, and writes a result into a two-entry
// output queue. Result channel: a result word is shown while empty is low
// and leaves on pop; it passes through the frame queue, then the output queue.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_addr
// (0 header byte, 1 angle frame type) at the clock edge.
// Reset clears the byte counter, turn counts, last yaws and start yaw and
// restores the register defaults. When pop stays low, the output queue and
// then the frame queue fill and full rises; full is set only by the frame
// queue, so bytes keep flowing until two frames wait behind two results.
module imu_frame_yaw_unwrap #(
    parameter int FRAME_LEN = 11,
    parameter int TURN_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [iyu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [iyu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           push,
    output logic                           full,
    input  iyu_pkg::sample_t               sample,
    input  logic                           pop,
    output logic                           empty,
    output iyu_pkg::result_t               result
);

    import iyu_pkg::*;

    localparam int QDEPTH = 2;

    logic                    accept;
    logic                    frame_push;
    frame_t                  frame_in;
    logic [$bits(frame_t)-1:0] frame_vec;
    logic                    frame_empty;
    logic                    frame_pop;
    logic                    res_push;
    logic                    res_full;
    result_t                 res;
    logic [$bits(result_t)-1:0] result_vec;

    assign accept = push & ~full;

    iyu_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .sample     (sample),
        .frame_push (frame_push),
        .frame      (frame_in)
    );

    iyu_fifo #(
        .WIDTH ($bits(frame_t)),
        .DEPTH (QDEPTH)
    ) u_frame_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_push),
        .wr_data (frame_in),
        .rd_en   (frame_pop),
        .rd_data (frame_vec),
        .full    (full),
        .empty   (frame_empty)
    );

    iyu_back #(
        .TURN_BITS (TURN_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_avail (~frame_empty),
        .frame       (frame_t'(frame_vec)),
        .res_full    (res_full),
        .frame_pop   (frame_pop),
        .res_push    (res_push),
        .res         (res)
    );

    iyu_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QDEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (result_vec),
        .full    (res_full),
        .empty   (empty)
    );

    assign result = result_t'(result_vec);

endmodule

FILE: sv/iyu_checker.sv
// Port checker for the yaw unwrap block and its bind to the top level.
module iyu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pop,
    input logic             empty,
    input iyu_pkg::result_t result
);

    import iyu_pkg::*;

    a_delta_mode1: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.yaw_delta != 32'd0) |-> (result.mode_out && result.angle_valid))
        else $error("yaw delta on a non-angle or start frame");

    a_non_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.angle_valid) |-> (result.unwrapped_yaw == 32'sd0))
        else $error("non-angle frame carries a yaw");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result withdrawn");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("waiting result changed");

endmodule

bind imu_frame_yaw_unwrap iyu_checker u_iyu_checker (.*);
